[rtl/core/rrl_pkg.sv]
// shared types and constants for the round-robin ready list
// no dependencies; imported by every module of the block but rrl_ram
`timescale 1ns / 1ps
`default_nettype none

package rrl_pkg;

  localparam int MAX_TASKS      = 64;
  localparam int ID_W           = $clog2(MAX_TASKS);
  localparam int CNT_W          = $clog2(MAX_TASKS + 1);
  localparam int TICK_BITS      = 32;
  localparam int TICK_LEN_W     = 24;
  localparam int CHARGE_W       = 56;
  localparam logic [TICK_LEN_W-1:0] TICK_LEN_RESET = 24'd4000000;

  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_PICK    = 3'd2,
    OP_DIED    = 3'd3,
    OP_BEGIN   = 3'd4,
    OP_END     = 3'd5
  } rrl_op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALREADY_Q  = 2'd1,
    ST_NOT_QUEUED = 2'd2,
    ST_NOT_REG    = 2'd3
  } rrl_status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic mul;
  } rrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_pick;
  } rrl_stat_t;

endpackage

`default_nettype wire

[rtl/core/rrl_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/rrl_ctrl.sv]
// sequencing controller for the ready list: idle, execute, multiply
// depends on rrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrl_ctrl
  import rrl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire rrl_stat_t stat,
  output logic           busy,
  output logic           out_strobe,
  output rrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_MUL  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && start;
    cmd.exec   = (state_r == S_EXEC);
    cmd.mul    = (state_r == S_MUL);
  end

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_pick) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      S_MUL: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_EXEC) else $error("accept did not enter execute");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> state_r == S_IDLE) else $error("result strobe outside idle");

  a_mul_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> $past(state_r) == S_EXEC) else $error("multiply without execute");

endmodule

`default_nettype wire

[rtl/core/rrl_dp.sv]
// datapath of the ready list: link rams, stamp ram, flags, counts, charge multiplier
// depends on rrl_pkg and rrl_ram
`timescale 1ns / 1ps
`default_nettype none

module rrl_dp
  import rrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rrl_cmd_t              cmd,
  output rrl_stat_t                  stat,
  input  wire logic [2:0]            in_operation,
  input  wire logic [ID_W-1:0]       in_task_id,
  input  wire logic [ID_W-1:0]       in_prev_id,
  input  wire logic                  in_prev_valid,
  input  wire logic [TICK_BITS-1:0]  in_now_ticks,
  input  wire logic                  cfg_we,
  input  wire logic [TICK_LEN_W-1:0] cfg_wdata,
  output logic [1:0]                 out_status,
  output logic                       out_chosen_valid,
  output logic [ID_W-1:0]            out_chosen_task,
  output logic                       out_charged_valid,
  output logic [CHARGE_W-1:0]        out_charged_ns,
  output logic [CNT_W-1:0]           out_queued_count,
  output logic [CNT_W-1:0]           out_registered_count,
  output logic                       out_sleepers_pending,
  output logic [CNT_W-1:0]           out_visible_count
);

  // captured request
  logic [2:0]           op_r;
  logic [ID_W-1:0]      tid_r;
  logic [ID_W-1:0]      pid_r;
  logic                 pvalid_r;
  logic [TICK_BITS-1:0] now_r;

  // list state
  logic [MAX_TASKS-1:0]  queued_r, queued_nxt;
  logic [MAX_TASKS-1:0]  reg_r, reg_nxt;
  logic [ID_W-1:0]       head_r, head_nxt;
  logic [ID_W-1:0]       tail_r, tail_nxt;
  logic [ID_W-1:0]       rot_r, rot_nxt;
  logic                  rot_valid_r, rot_valid_nxt;
  logic [CNT_W-1:0]      qcount_r, qcount_nxt;
  logic [CNT_W-1:0]      rcount_r, rcount_nxt;
  logic                  active_r, active_nxt;
  logic [TICK_LEN_W-1:0] tick_len_r;

  // charge pipeline
  logic [TICK_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                 charge_r, charge_nxt;

  // result payload
  logic [1:0]          status_r, status_nxt;
  logic                chosen_valid_r, chosen_valid_nxt;
  logic [ID_W-1:0]     chosen_task_r, chosen_task_nxt;
  logic                charged_valid_r;
  logic [CHARGE_W-1:0] charged_ns_r;

  // ram ports
  logic                 succ_we, pred_we, stamp_we;
  logic [ID_W-1:0]      succ_waddr, succ_wdata, succ_raddr, succ_rdata;
  logic [ID_W-1:0]      pred_waddr, pred_wdata, pred_rdata;
  logic [ID_W-1:0]      stamp_waddr;
  logic [TICK_BITS-1:0] stamp_rdata;

  // reads are issued straight from the request ports so data is ready in execute
  assign succ_raddr = (in_operation == OP_PICK) ? rot_r : in_task_id;

  rrl_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_succ (
    .clk   (clk),
    .we    (succ_we),
    .waddr (succ_waddr),
    .wdata (succ_wdata),
    .raddr (succ_raddr),
    .rdata (succ_rdata)
  );

  rrl_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_pred (
    .clk   (clk),
    .we    (pred_we),
    .waddr (pred_waddr),
    .wdata (pred_wdata),
    .raddr (in_task_id),
    .rdata (pred_rdata)
  );

  rrl_ram #(.WIDTH(TICK_BITS), .DEPTH(MAX_TASKS)) u_stamp (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_r),
    .raddr (in_prev_id),
    .rdata (stamp_rdata)
  );

  assign stat.is_pick = (op_r == OP_PICK);

  always_comb begin
    queued_nxt       = queued_r;
    reg_nxt          = reg_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    rot_nxt          = rot_r;
    rot_valid_nxt    = rot_valid_r;
    qcount_nxt       = qcount_r;
    rcount_nxt       = rcount_r;
    active_nxt       = active_r;
    elapsed_nxt      = now_r - stamp_rdata;
    charge_nxt       = 1'b0;
    status_nxt       = ST_OK;
    chosen_valid_nxt = 1'b0;
    chosen_task_nxt  = '0;
    succ_we          = 1'b0;
    succ_waddr       = tail_r;
    succ_wdata       = tid_r;
    pred_we          = 1'b0;
    pred_waddr       = tid_r;
    pred_wdata       = tail_r;
    stamp_we         = 1'b0;
    stamp_waddr      = tid_r;

    case (op_r)
      OP_ENQUEUE: begin
        if (queued_r[tid_r]) begin
          status_nxt = ST_ALREADY_Q;
        end else begin
          if (qcount_r == '0) begin
            head_nxt      = tid_r;
            rot_nxt       = tid_r;
            rot_valid_nxt = 1'b1;
          end else begin
            succ_we = 1'b1;
            pred_we = 1'b1;
          end
          tail_nxt          = tid_r;
          queued_nxt[tid_r] = 1'b1;
          qcount_nxt        = qcount_r + 1'b1;
          if (!reg_r[tid_r]) begin
            reg_nxt[tid_r] = 1'b1;
            stamp_we       = 1'b1;
            rcount_nxt     = rcount_r + 1'b1;
          end
        end
      end
      OP_DEQUEUE: begin
        if (!queued_r[tid_r]) begin
          status_nxt = ST_NOT_QUEUED;
        end else begin
          if (rot_valid_r && (rot_r == tid_r)) begin
            rot_nxt = (tid_r == tail_r) ? head_r : succ_rdata;
          end
          // unlink: successor of predecessor
          if (tid_r == head_r) begin
            head_nxt = succ_rdata;
          end else begin
            succ_we    = 1'b1;
            succ_waddr = pred_rdata;
            succ_wdata = succ_rdata;
          end
          // unlink: predecessor of successor
          if (tid_r == tail_r) begin
            tail_nxt = pred_rdata;
          end else begin
            pred_we    = 1'b1;
            pred_waddr = succ_rdata;
            pred_wdata = pred_rdata;
          end
          queued_nxt[tid_r] = 1'b0;
          qcount_nxt        = qcount_r - 1'b1;
          if (qcount_r == CNT_W'(1)) begin
            rot_valid_nxt = 1'b0;
            rot_nxt       = '0;
            head_nxt      = '0;
            tail_nxt      = '0;
          end
        end
      end
      OP_PICK: begin
        if (active_r && rot_valid_r) begin
          rot_nxt          = (rot_r == tail_r) ? head_r : succ_rdata;
          charge_nxt       = pvalid_r && reg_r[pid_r];
          stamp_we         = 1'b1;
          stamp_waddr      = rot_r;
          chosen_valid_nxt = 1'b1;
          chosen_task_nxt  = rot_r;
        end
      end
      OP_DIED: begin
        if (!reg_r[tid_r]) begin
          status_nxt = ST_NOT_REG;
        end else if (queued_r[tid_r]) begin
          status_nxt = ST_ALREADY_Q;
        end else begin
          reg_nxt[tid_r] = 1'b0;
          rcount_nxt     = rcount_r - 1'b1;
        end
      end
      OP_BEGIN: begin
        active_nxt = 1'b1;
      end
      OP_END: begin
        active_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    if (!cmd.exec) begin
      succ_we  = 1'b0;
      pred_we  = 1'b0;
      stamp_we = 1'b0;
    end
  end

  // request capture and payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_operation;
      tid_r    <= in_task_id;
      pid_r    <= in_prev_id;
      pvalid_r <= in_prev_valid;
      now_r    <= in_now_ticks;
    end
    if (cmd.exec) begin
      elapsed_r       <= elapsed_nxt;
      charge_r        <= charge_nxt;
      status_r        <= status_nxt;
      chosen_valid_r  <= chosen_valid_nxt;
      chosen_task_r   <= chosen_task_nxt;
      charged_valid_r <= charge_nxt;
      charged_ns_r    <= '0;
    end
    if (cmd.mul) begin
      charged_ns_r <= charge_r ? (CHARGE_W'(elapsed_r) * CHARGE_W'(tick_len_r)) : '0;
    end
  end

  // list control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r    <= '0;
      reg_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      rot_r       <= '0;
      rot_valid_r <= 1'b0;
      qcount_r    <= '0;
      rcount_r    <= '0;
      active_r    <= 1'b0;
      tick_len_r  <= TICK_LEN_RESET;
    end else begin
      if (cmd.exec) begin
        queued_r    <= queued_nxt;
        reg_r       <= reg_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        rot_r       <= rot_nxt;
        rot_valid_r <= rot_valid_nxt;
        qcount_r    <= qcount_nxt;
        rcount_r    <= rcount_nxt;
        active_r    <= active_nxt;
      end
      if (cfg_we) begin
        tick_len_r <= cfg_wdata;
      end
    end
  end

  assign out_status           = status_r;
  assign out_chosen_valid     = chosen_valid_r;
  assign out_chosen_task      = chosen_task_r;
  assign out_charged_valid    = charged_valid_r;
  assign out_charged_ns       = charged_ns_r;
  assign out_queued_count     = qcount_r;
  assign out_registered_count = rcount_r;
  assign out_sleepers_pending = (qcount_r != rcount_r);
  assign out_visible_count    = active_r ? qcount_r : '0;

  a_qcount_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == qcount_r) else $error("queued count out of step with flags");

  a_rcount_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(reg_r) == rcount_r) else $error("registered count out of step with flags");

  a_queued_registered: assert property (@(posedge clk) disable iff (!rst_n)
    (queued_r & ~reg_r) == '0) else $error("queued task not registered");

  a_rot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rot_valid_r == (qcount_r != '0)) else $error("rotate pointer validity mismatch");

endmodule

`default_nettype wire

[rtl/core/round_robin_ready_list_core.sv]
// top level of the round-robin ready list: controller plus datapath
// depends on rrl_pkg, rrl_ctrl, rrl_dp (and rrl_ram through the datapath)
// result: the strobe is registered and rises once the sequencer leaves execute,
//   or leaves multiply on a pick, which holds the registered 32 x 24 charge multiply
// requests: a new request is taken only once the last one has left execute, or
//   multiply for a pick; the link and stamp ram reads are registered ahead of execute
// reset: synchronous active-low rst_n empties the list, clears flags and counts,
//   deactivates and loads tick length 4000000; no clearing pass; receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module round_robin_ready_list_core
  import rrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_operation,
  input  wire logic [ID_W-1:0]       in_task_id,
  input  wire logic [ID_W-1:0]       in_prev_id,
  input  wire logic                  in_prev_valid,
  input  wire logic [TICK_BITS-1:0]  in_now_ticks,
  // tick length register
  input  wire logic                  cfg_we,
  input  wire logic [TICK_LEN_W-1:0] cfg_wdata,
  // result channel
  output logic                       out_strobe,
  output logic [1:0]                 out_status,
  output logic                       out_chosen_valid,
  output logic [ID_W-1:0]            out_chosen_task,
  output logic                       out_charged_valid,
  output logic [CHARGE_W-1:0]        out_charged_ns,
  output logic [CNT_W-1:0]           out_queued_count,
  output logic [CNT_W-1:0]           out_registered_count,
  output logic                       out_sleepers_pending,
  output logic [CNT_W-1:0]           out_visible_count
);

  // command and status between sequencer and datapath
  rrl_cmd_t  cmd;
  rrl_stat_t stat;

  // sequencer: idle -> execute -> (multiply on pick) -> idle
  rrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // datapath: ram reads launch at accept, list update and writes in execute,
  // charge product is registered at the end of the multiply state
  rrl_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_operation         (in_operation),
    .in_task_id           (in_task_id),
    .in_prev_id           (in_prev_id),
    .in_prev_valid        (in_prev_valid),
    .in_now_ticks         (in_now_ticks),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_status           (out_status),
    .out_chosen_valid     (out_chosen_valid),
    .out_chosen_task      (out_chosen_task),
    .out_charged_valid    (out_charged_valid),
    .out_charged_ns       (out_charged_ns),
    .out_queued_count     (out_queued_count),
    .out_registered_count (out_registered_count),
    .out_sleepers_pending (out_sleepers_pending),
    .out_visible_count    (out_visible_count)
  );

  // a request is only taken while the sequencer is idle
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.accept) else $error("request accepted while busy");

  // every strobe follows an accepted request through execute, or execute and multiply
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(cmd.accept, 2) || $past(cmd.accept, 3)))
    else $error("result strobe without a request");

  // a strobed pick result never claims a charge without a chosen task
  a_charge_needs_choice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_charged_valid) |-> out_chosen_valid)
    else $error("charge reported without a chosen task");

endmodule

`default_nettype wire

[sim/ready_list_checker.sv]
`timescale 1ns / 1ps
// self-checking monitor for the round-robin ready list: mirrors the list state,
// predicts one result per accepted request and compares it with the strobed result
// depends on rrl_pkg only; instantiated beside the block by the test top
module ready_list_checker
  import rrl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [ID_W-1:0]       in_task_id,
  input  logic [ID_W-1:0]       in_prev_id,
  input  logic                  in_prev_valid,
  input  logic [TICK_BITS-1:0]  in_now_ticks,
  input  logic                  cfg_we,
  input  logic [TICK_LEN_W-1:0] cfg_wdata,
  input  logic                  out_strobe,
  input  logic [1:0]            out_status,
  input  logic                  out_chosen_valid,
  input  logic [ID_W-1:0]       out_chosen_task,
  input  logic                  out_charged_valid,
  input  logic [CHARGE_W-1:0]   out_charged_ns,
  input  logic [CNT_W-1:0]      out_queued_count,
  input  logic [CNT_W-1:0]      out_registered_count,
  input  logic                  out_sleepers_pending,
  input  logic [CNT_W-1:0]      out_visible_count,
  output int                    pending_count,
  output int                    failure_count,
  output int                    request_count,
  output int                    pick_count,
  output int                    charge_count
);

  typedef struct packed {
    rrl_status_t          status;
    logic                 chosen_valid;
    logic [ID_W-1:0]      chosen_task;
    logic                 charged_valid;
    logic [CHARGE_W-1:0]  charged_ns;
    logic [CNT_W-1:0]     queued_count;
    logic [CNT_W-1:0]     registered_count;
    logic                 sleepers_pending;
    logic [CNT_W-1:0]     visible_count;
  } list_result_t;

  // mirrored list state
  logic [ID_W-1:0]       next_link [MAX_TASKS];
  logic [ID_W-1:0]       prev_link [MAX_TASKS];
  logic [TICK_BITS-1:0]  run_stamp [MAX_TASKS];
  logic [MAX_TASKS-1:0]  is_queued;
  logic [MAX_TASKS-1:0]  is_registered;
  logic [ID_W-1:0]       head;
  logic [ID_W-1:0]       tail;
  logic [ID_W-1:0]       rotor;
  logic                  rotor_valid;
  logic [CNT_W-1:0]      queued_total;
  logic [CNT_W-1:0]      registered_total;
  logic                  active;
  logic [TICK_LEN_W-1:0] tick_len;

  list_result_t expected_results [$];

  initial begin
    pending_count = 0;
    failure_count = 0;
    request_count = 0;
    pick_count    = 0;
    charge_count  = 0;
  end

  function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] t);
    return (t == tail) ? head : next_link[t];
  endfunction

  task automatic clear_list_state();
    is_queued        = '0;
    is_registered    = '0;
    head             = '0;
    tail             = '0;
    rotor            = '0;
    rotor_valid      = 1'b0;
    queued_total     = '0;
    registered_total = '0;
    active           = 1'b0;
    tick_len         = TICK_LEN_RESET;
  endtask

  task automatic predict_list_result(input logic [2:0] op, input logic [ID_W-1:0] tid,
                                     input logic [ID_W-1:0] pid, input logic pv,
                                     input logic [TICK_BITS-1:0] now,
                                     output list_result_t r);
    logic [ID_W-1:0]      picked;
    logic [TICK_BITS-1:0] elapsed;
    r = '0;
    case (op)
      OP_ENQUEUE: begin
        if (is_queued[tid]) begin
          r.status = ST_ALREADY_Q;
        end else begin
          if (queued_total == 0) begin
            head = tid;
          end else begin
            next_link[tail] = tid;
            prev_link[tid]  = tail;
          end
          tail           = tid;
          is_queued[tid] = 1'b1;
          queued_total++;
          if (!is_registered[tid]) begin
            is_registered[tid] = 1'b1;
            run_stamp[tid]     = now;
            registered_total++;
          end
          if (queued_total == 1) begin
            rotor       = tid;
            rotor_valid = 1'b1;
          end
        end
      end
      OP_DEQUEUE: begin
        if (!is_queued[tid]) begin
          r.status = ST_NOT_QUEUED;
        end else begin
          if (rotor_valid && rotor == tid) rotor = ring_next(tid);
          if (tid == head) head = next_link[tid];
          else next_link[prev_link[tid]] = next_link[tid];
          if (tid == tail) tail = prev_link[tid];
          else prev_link[next_link[tid]] = prev_link[tid];
          is_queued[tid] = 1'b0;
          queued_total--;
          // list emptied: pointers go back to their idle values
          if (queued_total == 0) begin
            rotor_valid = 1'b0;
            rotor       = '0;
            head        = '0;
            tail        = '0;
          end
        end
      end
      OP_PICK: begin
        if (active && rotor_valid) begin
          picked = rotor;
          rotor  = ring_next(picked);
          // charge uses the old stamp even when prev is the chosen task
          if (pv && is_registered[pid]) begin
            elapsed         = now - run_stamp[pid];
            r.charged_ns    = CHARGE_W'(elapsed) * CHARGE_W'(tick_len);
            r.charged_valid = 1'b1;
          end
          run_stamp[picked] = now;
          r.chosen_valid    = 1'b1;
          r.chosen_task     = picked;
        end
      end
      OP_DIED: begin
        if (!is_registered[tid]) begin
          r.status = ST_NOT_REG;
        end else if (is_queued[tid]) begin
          r.status = ST_ALREADY_Q;
        end else begin
          is_registered[tid] = 1'b0;
          registered_total--;
        end
      end
      OP_BEGIN: active = 1'b1;
      OP_END:   active = 1'b0;
      default: ;
    endcase
    r.queued_count     = queued_total;
    r.registered_count = registered_total;
    r.sleepers_pending = (registered_total != queued_total);
    r.visible_count    = active ? queued_total : '0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failure_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      clear_list_state();
      expected_results.delete();
    end else begin
      // a result strobed now belongs to a request accepted earlier
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result strobed with no request outstanding");
          failure_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",           want.status,           out_status);
          check_field("chosen_valid",     want.chosen_valid,     out_chosen_valid);
          check_field("chosen_task",      want.chosen_task,      out_chosen_task);
          check_field("charged_valid",    want.charged_valid,    out_charged_valid);
          check_field("charged_ns",       want.charged_ns,       out_charged_ns);
          check_field("queued_count",     want.queued_count,     out_queued_count);
          check_field("registered_count", want.registered_count, out_registered_count);
          check_field("sleepers_pending", want.sleepers_pending, out_sleepers_pending);
          check_field("visible_count",    want.visible_count,    out_visible_count);
        end
      end
      if (cfg_we) tick_len = cfg_wdata;
      if (start && !busy) begin
        predict_list_result(in_operation, in_task_id, in_prev_id, in_prev_valid,
                            in_now_ticks, want);
        expected_results.push_back(want);
        request_count++;
        if (want.chosen_valid) pick_count++;
        if (want.charged_valid) charge_count++;
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[sim/round_robin_ready_list_core_test.sv]
`timescale 1ns / 1ps
// test top for the round-robin ready list: drives requests and tick length writes,
// gives the verdict; depends on rrl_pkg, round_robin_ready_list_core, ready_list_checker
module round_robin_ready_list_core_test;
  import rrl_pkg::*;

  // operation codes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 230;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic [2:0]            in_operation  = OP_ENQUEUE;
  logic [ID_W-1:0]       in_task_id    = '0;
  logic [ID_W-1:0]       in_prev_id    = '0;
  logic                  in_prev_valid = 1'b0;
  logic [TICK_BITS-1:0]  in_now_ticks  = '0;
  logic                  cfg_we        = 1'b0;
  logic [TICK_LEN_W-1:0] cfg_wdata     = '0;

  logic                  busy;
  logic                  out_strobe;
  logic [1:0]            out_status;
  logic                  out_chosen_valid;
  logic [ID_W-1:0]       out_chosen_task;
  logic                  out_charged_valid;
  logic [CHARGE_W-1:0]   out_charged_ns;
  logic [CNT_W-1:0]      out_queued_count;
  logic [CNT_W-1:0]      out_registered_count;
  logic                  out_sleepers_pending;
  logic [CNT_W-1:0]      out_visible_count;

  int pending_count;
  int failure_count;
  int request_count;
  int pick_count;
  int charge_count;
  int cycle_count = 0;

  // tick counter, advanced at random with each random request, that the requests mostly follow
  logic [TICK_BITS-1:0] tick_now = '0;

  // per-phase sender idling (percent) and tick length written before the phase
  int                    idle_pct   [PHASES] = '{0, 49, 0, 29, 49};
  logic [TICK_LEN_W-1:0] phase_tick [PHASES] = '{24'd1, 24'hFFFFFF, 24'd10000000, 24'd0,
                                                 24'd123457};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_ready_list_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_task_id           (in_task_id),
    .in_prev_id           (in_prev_id),
    .in_prev_valid        (in_prev_valid),
    .in_now_ticks         (in_now_ticks),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_chosen_valid     (out_chosen_valid),
    .out_chosen_task      (out_chosen_task),
    .out_charged_valid    (out_charged_valid),
    .out_charged_ns       (out_charged_ns),
    .out_queued_count     (out_queued_count),
    .out_registered_count (out_registered_count),
    .out_sleepers_pending (out_sleepers_pending),
    .out_visible_count    (out_visible_count)
  );

  ready_list_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_task_id           (in_task_id),
    .in_prev_id           (in_prev_id),
    .in_prev_valid        (in_prev_valid),
    .in_now_ticks         (in_now_ticks),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_chosen_valid     (out_chosen_valid),
    .out_chosen_task      (out_chosen_task),
    .out_charged_valid    (out_charged_valid),
    .out_charged_ns       (out_charged_ns),
    .out_queued_count     (out_queued_count),
    .out_registered_count (out_registered_count),
    .out_sleepers_pending (out_sleepers_pending),
    .out_visible_count    (out_visible_count),
    .pending_count        (pending_count),
    .failure_count        (failure_count),
    .request_count        (request_count),
    .pick_count           (pick_count),
    .charge_count         (charge_count)
  );

  // watchdog: a hang or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  // (busy is sampled at the edge, before the block updates it)
  task automatic send_request(input logic [2:0] op, input logic [ID_W-1:0] tid,
                              input logic [ID_W-1:0] pid, input logic pv,
                              input logic [TICK_BITS-1:0] now);
    in_operation  <= op;
    in_task_id    <= tid;
    in_prev_id    <= pid;
    in_prev_valid <= pv;
    in_now_ticks  <= now;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every outstanding request has its result;
  // the count is read mid-cycle so it never races the checker
  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_tick_length(input logic [TICK_LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random_request(input int pool_hi);
    int                   roll;
    logic [2:0]           op;
    logic [ID_W-1:0]      tid;
    logic [ID_W-1:0]      pid;
    logic                 pv;
    logic [TICK_BITS-1:0] now;
    roll = $urandom_range(99);
    // enqueue and pick dominate so the list fills up and rotates
    if (roll < 30)      op = OP_ENQUEUE;
    else if (roll < 50) op = OP_DEQUEUE;
    else if (roll < 78) op = OP_PICK;
    else if (roll < 88) op = OP_DIED;
    else if (roll < 94) op = OP_BEGIN;
    else if (roll < 97) op = OP_END;
    else                op = roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
    // mostly a small pool of ids so dequeue, death and charging hit known tasks
    tid = ($urandom_range(9) < 7) ? ID_W'($urandom_range(pool_hi)) : ID_W'($urandom);
    pid = ($urandom_range(9) < 7) ? ID_W'($urandom_range(pool_hi)) : ID_W'($urandom);
    pv  = ($urandom_range(3) != 0);
    if ($urandom_range(49) == 0) tick_now = $urandom;
    else tick_now = tick_now + $urandom_range(2000);
    now = ($urandom_range(19) == 0) ? TICK_BITS'($urandom) : tick_now;
    send_request(op, tid, pid, pv, now);
  endtask

  initial begin
    int  pool_hi;
    bit  quiet;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset tick length
    send_request(OP_PICK,     6'd0,  6'd0,  1'b1, 32'd0);         // inactive and empty
    send_request(OP_SPARE_LO, 6'd63, 6'd63, 1'b1, 32'hFFFFFFFF);  // ignored codes
    send_request(OP_SPARE_HI, 6'd0,  6'd0,  1'b0, 32'd0);
    send_request(OP_DEQUEUE,  6'd5,  6'd0,  1'b0, 32'd10);        // not queued
    send_request(OP_DIED,     6'd5,  6'd0,  1'b0, 32'd10);        // not registered
    send_request(OP_ENQUEUE,  6'd0,  6'd0,  1'b0, 32'd0);
    send_request(OP_ENQUEUE,  6'd63, 6'd0,  1'b0, 32'hFFFFFFFF);
    send_request(OP_ENQUEUE,  6'd0,  6'd0,  1'b0, 32'd7);         // already queued
    send_request(OP_DIED,     6'd0,  6'd0,  1'b0, 32'd7);         // dies while queued
    send_request(OP_PICK,     6'd0,  6'd63, 1'b1, 32'd9);         // list filled, inactive
    send_request(OP_BEGIN,    6'd0,  6'd0,  1'b0, 32'd9);
    send_request(OP_PICK,     6'd0,  6'd63, 1'b1, 32'd0);         // stamp wraps past zero
    send_request(OP_PICK,     6'd0,  6'd7,  1'b1, 32'd40);        // prev not registered, pointer wraps to head
    send_request(OP_PICK,     6'd0,  6'd0,  1'b0, 32'd80);        // no prev task, no charge
    send_request(OP_ENQUEUE,  6'd7,  6'd0,  1'b0, 32'd90);
    send_request(OP_ENQUEUE,  6'd20, 6'd0,  1'b0, 32'd95);
    send_request(OP_DEQUEUE,  6'd7,  6'd0,  1'b0, 32'd99);        // middle member
    send_request(OP_DEQUEUE,  6'd0,  6'd0,  1'b0, 32'd99);        // head member
    send_request(OP_PICK,     6'd0,  6'd63, 1'b1, 32'hFFFFFFFF);  // elapsed near the 32-bit limit
    send_request(OP_DEQUEUE,  6'd20, 6'd0,  1'b0, 32'd100);       // tail member
    send_request(OP_DEQUEUE,  6'd63, 6'd0,  1'b0, 32'd100);       // list empties
    send_request(OP_PICK,     6'd0,  6'd63, 1'b1, 32'd101);       // active but empty
    send_request(OP_DIED,     6'd63, 6'd0,  1'b0, 32'd102);
    send_request(OP_DIED,     6'd0,  6'd0,  1'b0, 32'd102);
    send_request(OP_END,      6'd0,  6'd0,  1'b0, 32'd103);
    send_request(OP_PICK,     6'd0,  6'd0,  1'b0, 32'd104);

    // random phases, each with its own tick length and sender idling
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_results();
      write_tick_length(phase_tick[ph]);
      pool_hi = 7;
      quiet   = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          // vary the id pool and allow stretches with no idling
          case ($urandom_range(3))
            0:       pool_hi = 3;
            1:       pool_hi = 7;
            2:       pool_hi = 15;
            default: pool_hi = 63;
          endcase
          quiet = ($urandom_range(2) == 0);
        end
        send_random_request(pool_hi);
        if ($urandom_range(63) == 0) begin
          wait_for_results();
        end else if (!quiet && $urandom_range(99) < idle_pct[ph]) begin
          pause_sender($urandom_range(1, 4));
        end
      end
    end

    // drain, then watch a little longer for stray strobes
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("summary: %0d requests checked over %0d tick lengths", request_count, PHASES + 1);
    $display("summary: %0d picks returned a task, %0d charged the previous one",
             pick_count, charge_count);
    if (failure_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
